// ===== sv/npcs_pkg.sv =====
package npcs_pkg;

	localparam int COMP_W              = 5;
	localparam int COLOUR_W            = 16;
	localparam int INDEX_W             = 8;
	localparam int DIST_W              = 12;
	localparam int SQ_W                = 2 * COMP_W;
	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int MAX_DIST            = 3 * ((1 << COMP_W) - 1) * ((1 << COMP_W) - 1);

	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	typedef struct packed {
		logic [COMP_W-1:0] blue;
		logic [COMP_W-1:0] green;
		logic [COMP_W-1:0] red;
	} rgb_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// RGB555: red bits 0-4, green 5-9, blue 10-14, bit 15 unused
	function automatic rgb_t unpack_rgb(input logic [COLOUR_W-1:0] word);
		rgb_t c;
		c.red   = word[COMP_W-1:0];
		c.green = word[2*COMP_W-1:COMP_W];
		c.blue  = word[3*COMP_W-1:2*COMP_W];
		return c;
	endfunction

endpackage

// ===== sv/npcs_in_if.sv =====
interface npcs_in_if import npcs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                func;
	logic [INDEX_W-1:0]  entry_index;
	logic [COLOUR_W-1:0] entry_colour;
	logic [COMP_W-1:0]   target_red;
	logic [COMP_W-1:0]   target_green;
	logic [COMP_W-1:0]   target_blue;

	modport source (
		output valid, func, entry_index, entry_colour,
		output target_red, target_green, target_blue,
		input  ready
	);

	modport sink (
		input  valid, func, entry_index, entry_colour,
		input  target_red, target_green, target_blue,
		output ready
	);
endinterface

// ===== sv/npcs_out_if.sv =====
interface npcs_out_if import npcs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [INDEX_W-1:0] best_index;
	logic [DIST_W-1:0]  best_distance;

	modport source (
		output valid, best_index, best_distance,
		input  ready
	);

	modport sink (
		input  valid, best_index, best_distance,
		output ready
	);
endinterface

// ===== sv/npcs_ram.sv =====
module npcs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/npcs_dist.sv =====
module npcs_dist import npcs_pkg::*; (
	input  rgb_t              pix,
	input  rgb_t              tgt,
	output logic [DIST_W-1:0] sq_dist
);

	function automatic logic [SQ_W-1:0] comp_sq(input logic [COMP_W-1:0] a,
	                                            input logic [COMP_W-1:0] b);
		logic [COMP_W-1:0] d;
		d = (a >= b) ? (a - b) : (b - a);
		return SQ_W'(d) * SQ_W'(d);
	endfunction

	logic [SQ_W-1:0] sq_r;
	logic [SQ_W-1:0] sq_g;
	logic [SQ_W-1:0] sq_b;

	assign sq_r = comp_sq(pix.red,   tgt.red);
	assign sq_g = comp_sq(pix.green, tgt.green);
	assign sq_b = comp_sq(pix.blue,  tgt.blue);
	assign sq_dist = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);

endmodule

// ===== sv/nearest_palette_colour_search.sv =====
// Nearest palette color search over an RGB555 palette of PALETTE_ENTRIES words.
// A write transfer (func 0) stores entry_colour at entry_index and gives no
// result; an index at or above PALETTE_ENTRIES is dropped. A query transfer
// (func 1) scans every slot from 0 up through the palette RAM, one slot per
// cycle, into one shared distance unit and one compare register, and returns
// the slot with the smallest squared RGB distance (lowest slot on a tie) with
// that distance. The result is loaded into the result register once the last
// slot has been compared; ready is low from the query transfer until then, and
// longer while a previous result still waits. The result register lets the
// next transfer in while the result waits. Palette contents are undefined after
// reset: every slot must be written before the first query.
module nearest_palette_colour_search import npcs_pkg::*; #(
	parameter int PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	npcs_in_if.sink     req,
	npcs_out_if.source  rsp
);

	localparam int IDX_W = $clog2(PALETTE_ENTRIES);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PALETTE_ENTRIES - 1);

	state_t state_q;
	state_t state_d;

	logic              accept;
	logic              ram_we;
	logic              load;
	logic              issue_q;
	logic [IDX_W-1:0]  addr_q;
	logic              v_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              v_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic [DIST_W-1:0] dist_s2;
	logic [DIST_W-1:0] pix_dist;
	logic [COLOUR_W-1:0] rd_word;
	rgb_t              tgt_q;
	logic [IDX_W-1:0]  best_idx_q;
	logic [DIST_W-1:0] best_dist_q;
	logic              out_valid_q;
	logic [INDEX_W-1:0] out_idx_q;
	logic [DIST_W-1:0]  out_dist_q;

	assign accept = req.valid && req.ready;
	assign ram_we = accept && (req.func == FUNC_WRITE)
	                && ({1'b0, req.entry_index} < (INDEX_W + 1)'(PALETTE_ENTRIES));

	npcs_ram #(
		.WIDTH (COLOUR_W),
		.DEPTH (PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.we    (ram_we),
		.waddr (req.entry_index[IDX_W-1:0]),
		.wdata (req.entry_colour),
		.re    (issue_q),
		.raddr (addr_q),
		.rdata (rd_word)
	);

	npcs_dist u_dist (
		.pix     (unpack_rgb(rd_word)),
		.tgt     (tgt_q),
		.sq_dist (pix_dist)
	);

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		load      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && req.func == FUNC_QUERY) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (v_s2 && idx_s2 == LAST_IDX) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= 1'b0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			v_s1    <= issue_q;
			v_s2    <= v_s1;
			if (accept && req.func == FUNC_QUERY) begin
				issue_q <= 1'b1;
			end else if (issue_q && addr_q == LAST_IDX) begin
				issue_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && req.func == FUNC_QUERY) begin
			addr_q      <= '0;
			tgt_q.red   <= req.target_red;
			tgt_q.green <= req.target_green;
			tgt_q.blue  <= req.target_blue;
		end else if (issue_q) begin
			addr_q <= addr_q + 1'b1;
		end
		idx_s1  <= addr_q;
		idx_s2  <= idx_s1;
		dist_s2 <= pix_dist;
		// slot 0 seeds the best; strict less keeps the lowest slot on a tie
		if (v_s2 && (idx_s2 == '0 || dist_s2 < best_dist_q)) begin
			best_idx_q  <= idx_s2;
			best_dist_q <= dist_s2;
		end
		if (load) begin
			out_idx_q  <= INDEX_W'(best_idx_q);
			out_dist_q <= best_dist_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.best_index    = out_idx_q;
	assign rsp.best_distance = out_dist_q;

	a_dist_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.best_distance <= DIST_W'(MAX_DIST))
		else $error("best_distance out of range");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> {1'b0, rsp.best_index} < (INDEX_W + 1)'(PALETTE_ENTRIES))
		else $error("best_index beyond palette");

	a_query_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.func == FUNC_QUERY) |=>
		(state_q == ST_SCAN && issue_q && addr_q == '0))
		else $error("query transfer did not start a scan at slot 0");

	a_pipe_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 || v_s2) |-> state_q == ST_SCAN)
		else $error("scan pipeline active outside scan");

endmodule
